// ----- src/owtr_pkg.sv -----
// owtr_pkg: types, constants and helper functions of the one-wire temperature reader
// used by owtr_core and onewire_temperature_reader_unit, depends on nothing else
`default_nettype none

package owtr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_TAIL = 3'd3,
    PH_WRITE    = 3'd4,
    PH_READ     = 3'd5,
    PH_CONV     = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_RESET_TAIL    = 3'd2,
    CFG_SLOT          = 3'd3,
    CFG_PULSE         = 3'd4,
    CFG_SAMPLE        = 3'd5,
    CFG_CONVERT_WAIT  = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned TickW    = 20;

  localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT      = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  typedef struct packed {
    logic [11:0] reset_low_ticks;
    logic [9:0]  presence_wait_ticks;
    logic [9:0]  reset_tail_ticks;
    logic [9:0]  slot_ticks;
    logic [7:0]  pulse_ticks;
    logic [7:0]  sample_ticks;
    logic [19:0] convert_wait_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reset_low_ticks:     12'd480,
    presence_wait_ticks: 10'd66,
    reset_tail_ticks:    10'd36,
    slot_ticks:          10'd36,
    pulse_ticks:         8'd2,
    sample_ticks:        8'd1,
    convert_wait_ticks:  20'd1200
  };

  typedef struct packed {
    logic       device_present;
    logic [7:0] temperature;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } result_t;

  // command byte sent in each write step of the sequence
  function automatic logic [7:0] cmd_of(logic [2:0] step);
    logic [7:0] cmd;
    case (step)
      3'd1, 3'd5: cmd = CMD_SKIP_ROM;
      3'd2:       cmd = CMD_CONVERT;
      3'd6:       cmd = CMD_READ_SCRATCH;
      default:    cmd = 8'h00;
    endcase
    return cmd;
  endfunction

  // phase a step opens with
  function automatic phase_e step_phase(logic [2:0] step);
    phase_e ph;
    case (step)
      3'd0, 3'd4:             ph = PH_RST_LOW;
      3'd1, 3'd2, 3'd5, 3'd6: ph = PH_WRITE;
      3'd3:                   ph = PH_CONV;
      default:                ph = PH_READ;
    endcase
    return ph;
  endfunction

endpackage

`default_nettype wire

// ----- src/onewire_temperature_reader_unit.sv -----
// onewire_temperature_reader_unit: one result per tick transaction, m_axis_tvalid rises
// in the cycle after accept; one transaction per cycle sustained while m_axis_tready is high,
// the result register frees in the cycle it is taken so input and output run back to back.
// reset: sequencer idle, config registers at their defaults, result register empty.
// top level of the one-wire temperature reader, depends on owtr_pkg and owtr_core
`default_nettype none

module onewire_temperature_reader_unit
  import owtr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [0] start_req, [1] line_level
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [10:3] temperature, [11] device_present
  output      logic [15:0]         m_axis_tdata,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  result_t res;
  result_t res_q;
  logic    out_vld_q;
  logic    accept;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RESET_LOW:     cfg_q.reset_low_ticks     <= cfg_data_i[11:0];
        CFG_PRESENCE_WAIT: cfg_q.presence_wait_ticks <= cfg_data_i[9:0];
        CFG_RESET_TAIL:    cfg_q.reset_tail_ticks    <= cfg_data_i[9:0];
        CFG_SLOT:          cfg_q.slot_ticks          <= cfg_data_i[9:0];
        CFG_PULSE:         cfg_q.pulse_ticks         <= cfg_data_i[7:0];
        CFG_SAMPLE:        cfg_q.sample_ticks        <= cfg_data_i[7:0];
        CFG_CONVERT_WAIT:  cfg_q.convert_wait_ticks  <= cfg_data_i[19:0];
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  owtr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (accept),
    .start_i (s_axis_tdata[0]),
    .line_i  (s_axis_tdata[1]),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, res_q};

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted transaction did not produce a result");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while result register is stalled");

  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.done_res) |-> (res_q.busy_res && !res_q.drive_low))
    else $error("done tick must be busy with the line released");
`endif

endmodule

`default_nettype wire

// ----- src/owtr_core.sv -----
// owtr_core: bus sequencer state and the per-tick next-state logic
// depends on owtr_pkg
`default_nettype none

module owtr_core
  import owtr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    adv_i,
  input  wire logic    start_i,
  input  wire logic    line_i,
  input  wire cfg_t    cfg_i,
  output result_t      res_o
);

  phase_e            phase_q, phase_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [3:0]        bit_q, bit_d;
  logic [2:0]        step_q, step_d;
  logic [15:0]       shift_q, shift_d;
  logic [7:0]        temp_q, temp_d;
  logic              pres_q, pres_d;

  phase_e            ph;
  logic [TickW-1:0]  c;
  logic [TickW:0]    c1;
  logic [3:0]        bit_e;
  logic [2:0]        step_e;
  logic [2:0]        step_nx;
  logic [8:0]        samp_pt;
  logic [7:0]        cmd;
  logic              slot_end;
  logic              fin;
  logic              drive;
  logic              done;
  logic              launch;

  always_comb begin
    launch  = (phase_q == PH_IDLE) && start_i;
    ph      = launch ? PH_RST_LOW : phase_q;
    c       = launch ? '0 : tick_q;
    bit_e   = launch ? '0 : bit_q;
    step_e  = launch ? '0 : step_q;
    c1      = {1'b0, c} + 21'd1;
    step_nx = step_e + 3'd1;
    slot_end = c1 >= {11'd0, cfg_i.slot_ticks};
    samp_pt = {1'b0, cfg_i.pulse_ticks} + {1'b0, cfg_i.sample_ticks};
    cmd     = cmd_of(step_e);

    phase_d = ph;
    tick_d  = c;
    bit_d   = bit_e;
    step_d  = step_e;
    shift_d = shift_q;
    temp_d  = temp_q;
    pres_d  = pres_q;
    fin     = 1'b0;
    drive   = 1'b0;
    done    = 1'b0;

    case (ph)
      PH_IDLE: begin
        fin = 1'b1;
      end
      PH_RST_LOW: begin
        drive = 1'b1;
        fin   = c1 >= {9'd0, cfg_i.reset_low_ticks};
        if (fin) begin
          phase_d = PH_RST_WAIT;
          tick_d  = '0;
        end
      end
      PH_RST_WAIT: begin
        fin = c1 >= {11'd0, cfg_i.presence_wait_ticks};
        if (fin) begin
          pres_d  = ~line_i;
          phase_d = PH_RST_TAIL;
          tick_d  = '0;
        end
      end
      PH_RST_TAIL: begin
        fin = c1 >= {11'd0, cfg_i.reset_tail_ticks};
        if (fin) begin
          step_d  = step_nx;
          phase_d = step_phase(step_nx);
          tick_d  = '0;
          bit_d   = '0;
        end
      end
      PH_WRITE: begin
        // a zero bit keeps the line low up to the recovery tick
        drive = !slot_end && ((c < {12'd0, cfg_i.pulse_ticks}) || !cmd[bit_e[2:0]]);
        fin   = slot_end;
        if (fin) begin
          tick_d = '0;
          if (bit_e >= 4'd7) begin
            step_d  = step_nx;
            phase_d = step_phase(step_nx);
            bit_d   = '0;
          end else begin
            bit_d = bit_e + 4'd1;
          end
        end
      end
      PH_READ: begin
        drive = !slot_end && (c < {12'd0, cfg_i.pulse_ticks});
        // sample point past the slot end falls back to the last tick
        if ((c == {11'd0, samp_pt}) || (slot_end && (c < {11'd0, samp_pt}))) begin
          shift_d = {line_i, shift_q[15:1]};
        end
        fin = slot_end;
        if (fin) begin
          tick_d = '0;
          if (bit_e >= 4'd15) begin
            temp_d  = shift_d[11:4];
            done    = 1'b1;
            phase_d = PH_IDLE;
            step_d  = '0;
            bit_d   = '0;
          end else begin
            bit_d = bit_e + 4'd1;
          end
        end
      end
      PH_CONV: begin
        fin = c1 >= {1'b0, cfg_i.convert_wait_ticks};
        if (fin) begin
          step_d  = step_nx;
          phase_d = step_phase(step_nx);
          tick_d  = '0;
          bit_d   = '0;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        fin     = 1'b1;
      end
    endcase

    if (!fin) begin
      tick_d = c1[TickW-1:0];
    end

    res_o.drive_low      = drive;
    res_o.busy_res       = (ph != PH_IDLE);
    res_o.done_res       = done;
    res_o.temperature    = temp_d;
    res_o.device_present = pres_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      step_q  <= '0;
      shift_q <= '0;
      temp_q  <= '0;
      pres_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      step_q  <= step_d;
      shift_q <= shift_d;
      temp_q  <= temp_d;
      pres_q  <= pres_d;
    end
  end

endmodule

`default_nettype wire
